@@ rtl/tcsd_pkg.sv @@
// Shared types, constants and helpers for the tick clock with sleep deadlines.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none
package tcsd_pkg;

   localparam int MAX_SLEEPERS = 16;
   localparam int SLOT_W = (MAX_SLEEPERS > 1) ? $clog2(MAX_SLEEPERS) : 1;
   localparam int DIV_STEPS = 10;
   localparam int STEP_W = $clog2(DIV_STEPS);
   localparam logic [63:0] NS_PER_S = 64'd1000000000;
   localparam logic [19:0] NS_PER_MS = 20'd1000000;
   localparam logic [9:0] PERIOD_RESET = 10'd10;

   // One second is 2^9 times this odd factor; the magic number is its
   // rounded-up reciprocal scaled by 2^53, exact for any 32-bit numerator.
   localparam logic [20:0] DIV_D = 21'd1953125;
   localparam logic [32:0] DIV_MAGIC = 33'd4611686019;

   localparam logic [1:0] ACT_TICK = 2'd0;
   localparam logic [1:0] ACT_SLEEP = 2'd1;
   localparam logic [1:0] ACT_QUERY = 2'd2;

   localparam logic [1:0] KIND_WOKEN = 2'd0;
   localparam logic [1:0] KIND_RESCHED = 2'd1;
   localparam logic [1:0] KIND_TIME = 2'd2;
   localparam logic [1:0] KIND_STATUS = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_PASSED = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic        clock_is_monotonic;
      logic [7:0]  task_id;
      logic        absolute_mode;
      logic [31:0] request_seconds;
      logic [29:0] request_nanoseconds;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  woken_task;
      logic [34:0] time_seconds;
      logic [29:0] time_nanoseconds;
      logic [1:0]  status;
      logic        last_result;
   } rsp_type;

   typedef struct packed {
      logic              load_req;
      logic              tick_mul;
      logic              tick_add;
      logic              slp_mul;
      logic              slp_add1;
      logic              slp_add2;
      logic              div_start;
      logic              div_step;
      logic              div_fold;
      logic              slot_write;
      logic              slot_clear;
      logic              emit;
      logic              flush;
      logic [1:0]        kind;
      logic [1:0]        status;
      logic [SLOT_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       mono;
      logic       slot_valid;
      logic       slot_due;
      logic       d_passed;
      logic       even_tick;
      logic       out_free;
      logic       hold_valid;
   } sts_type;

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
   endfunction

endpackage
`default_nettype wire

@@ rtl/tcsd_ctrl.sv @@
// Controller state machine: sequences ticks, sleep requests and time queries.
// Depends on tcsd_pkg; drives the datapath only through command and status.
`default_nettype none
module tcsd_ctrl
   import tcsd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   input  sts_type   sts,
   output cmd_type   cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_TICK_MUL, S_TICK_ADD, S_TICK_SCAN, S_TICK_RESCHED,
      S_SLP_MUL, S_SLP_ADD1, S_SLP_ADD2, S_SLP_CMP, S_SLP_SCAN, S_SLP_EMIT,
      S_QRY_DIV, S_QRY_EMIT, S_FLUSH
   } state_type;

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [1:0]        status_ff, status_in;
   logic              can_emit;
   logic              idx_last;

   assign req_stall = (state_ff != S_IDLE);
   assign can_emit = !sts.hold_valid || sts.out_free;
   assign idx_last = (idx_ff == SLOT_W'(MAX_SLEEPERS - 1));

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      step_in = step_ff;
      status_in = status_ff;
      cmd = '0;
      cmd.idx = idx_ff;
      cmd.status = ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            idx_in = '0;
            case (sts.action)
               ACT_TICK: state_in = S_TICK_MUL;
               ACT_SLEEP: begin
                  if (sts.mono) begin
                     state_in = S_SLP_MUL;
                  end else begin
                     status_in = ST_INVALID;
                     state_in = S_SLP_EMIT;
                  end
               end
               ACT_QUERY: begin
                  if (sts.mono) begin
                     cmd.div_start = 1'b1;
                     step_in = '0;
                     state_in = S_QRY_DIV;
                  end else begin
                     state_in = S_QRY_EMIT;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_TICK_MUL: begin
            cmd.tick_mul = 1'b1;
            state_in = S_TICK_ADD;
         end
         S_TICK_ADD: begin
            cmd.tick_add = 1'b1;
            state_in = S_TICK_SCAN;
         end
         S_TICK_SCAN: begin
            cmd.kind = KIND_WOKEN;
            if (!sts.slot_due || can_emit) begin
               if (sts.slot_due) begin
                  cmd.emit = 1'b1;
                  cmd.slot_clear = 1'b1;
               end
               if (idx_last) begin
                  state_in = S_TICK_RESCHED;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_TICK_RESCHED: begin
            cmd.kind = KIND_RESCHED;
            if (!sts.even_tick) begin
               state_in = S_FLUSH;
            end else if (can_emit) begin
               cmd.emit = 1'b1;
               state_in = S_FLUSH;
            end
         end
         S_SLP_MUL: begin
            cmd.slp_mul = 1'b1;
            state_in = S_SLP_ADD1;
         end
         S_SLP_ADD1: begin
            cmd.slp_add1 = 1'b1;
            state_in = S_SLP_ADD2;
         end
         S_SLP_ADD2: begin
            cmd.slp_add2 = 1'b1;
            state_in = S_SLP_CMP;
         end
         S_SLP_CMP: begin
            if (sts.d_passed) begin
               status_in = ST_PASSED;
               state_in = S_SLP_EMIT;
            end else begin
               state_in = S_SLP_SCAN;
            end
         end
         S_SLP_SCAN: begin
            if (!sts.slot_valid) begin
               cmd.slot_write = 1'b1;
               status_in = ST_OK;
               state_in = S_SLP_EMIT;
            end else if (idx_last) begin
               status_in = ST_FULL;
               state_in = S_SLP_EMIT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_SLP_EMIT: begin
            cmd.kind = KIND_STATUS;
            cmd.status = status_ff;
            if (can_emit) begin
               cmd.emit = 1'b1;
               state_in = S_FLUSH;
            end
         end
         S_QRY_DIV: begin
            cmd.div_step = !step_ff[0];
            cmd.div_fold = step_ff[0];
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = S_QRY_EMIT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_QRY_EMIT: begin
            cmd.kind = KIND_TIME;
            cmd.status = sts.mono ? ST_OK : ST_INVALID;
            if (can_emit) begin
               cmd.emit = 1'b1;
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (!sts.hold_valid) begin
               state_in = S_IDLE;
            end else if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff <= '0;
         step_ff <= '0;
         status_ff <= ST_OK;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         step_ff <= step_in;
         status_ff <= status_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/tcsd_dpath.sv @@
// Datapath: clock registers, sleeper slots, divider, result hold and output register.
// Depends on tcsd_pkg; acts only on commands from the controller.
`default_nettype none
module tcsd_dpath
   import tcsd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  req_type   req_data,
   input  wire logic csr_we,
   input  wire logic [9:0] csr_wdata,
   input  cmd_type   cmd,
   output sts_type   sts,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output rsp_type   rsp_data
);

   logic [9:0]  period_ff;
   logic [63:0] tick_count_ff;
   logic [63:0] time_ff;
   logic [29:0] inc_ff;
   req_type     req_ff;
   logic [61:0] prod_ff;
   logic [63:0] d_ff;
   logic [54:0] div_y_ff;
   logic [20:0] div_r_ff;
   logic [10:0] div_q_ff;
   logic [8:0]  div_lo_ff;
   logic [34:0] quo_ff;
   logic [31:0] div_num;
   logic [64:0] div_prod;
   logic [31:0] div_back;
   logic [63:0] slot_deadline_ff [MAX_SLEEPERS];
   logic [7:0]  slot_task_ff [MAX_SLEEPERS];
   logic [MAX_SLEEPERS-1:0] slot_valid_ff;
   rsp_type     hold_ff;
   logic        hold_valid_ff;
   rsp_type     rsp_ff;
   logic        rsp_valid_ff;
   rsp_type     new_rsp;
   logic        out_free;
   logic [63:0] slot_dl;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign slot_dl = slot_deadline_ff[cmd.idx];

   // The time is divided by one second in five 11-bit digits of the time shifted
   // right by nine; each digit takes an estimate step followed by a remainder step.
   assign div_num = {div_r_ff, div_y_ff[54:44]};
   assign div_prod = 65'(div_num) * 65'(DIV_MAGIC);
   assign div_back = 32'(div_q_ff) * 32'(DIV_D);

   assign sts.action = req_ff.action;
   assign sts.mono = req_ff.clock_is_monotonic;
   assign sts.slot_valid = slot_valid_ff[cmd.idx];
   assign sts.slot_due = slot_valid_ff[cmd.idx] && (slot_dl <= time_ff);
   assign sts.d_passed = (d_ff <= time_ff);
   assign sts.even_tick = !tick_count_ff[0];
   assign sts.out_free = out_free;
   assign sts.hold_valid = hold_valid_ff;

   always_comb begin
      new_rsp = '0;
      new_rsp.result_kind = cmd.kind;
      new_rsp.status = cmd.status;
      if (cmd.kind == KIND_WOKEN) begin
         new_rsp.woken_task = slot_task_ff[cmd.idx];
      end
      if (cmd.kind == KIND_TIME && cmd.status == ST_OK) begin
         new_rsp.time_seconds = quo_ff;
         new_rsp.time_nanoseconds = {div_r_ff, div_lo_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.tick_mul) begin
         inc_ff <= 30'(period_ff * NS_PER_MS);
      end
      if (cmd.slp_mul) begin
         prod_ff <= 62'(req_ff.request_seconds * NS_PER_S[29:0]);
      end
      if (cmd.slp_add1) begin
         d_ff <= sat_add({2'b00, prod_ff}, {34'd0, req_ff.request_nanoseconds});
      end
      if (cmd.slp_add2 && !req_ff.absolute_mode) begin
         d_ff <= sat_add(time_ff, d_ff);
      end
      if (cmd.div_start) begin
         div_y_ff <= time_ff[63:9];
         div_lo_ff <= time_ff[8:0];
         div_r_ff <= '0;
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         div_q_ff <= div_prod[63:53];
      end else if (cmd.div_fold) begin
         div_r_ff <= 21'(div_num - div_back);
         div_y_ff <= {div_y_ff[43:0], 11'd0};
         quo_ff <= {quo_ff[23:0], div_q_ff};
      end
      if (cmd.slot_write) begin
         slot_deadline_ff[cmd.idx] <= d_ff;
         slot_task_ff[cmd.idx] <= req_ff.task_id;
      end
      if (cmd.emit) begin
         hold_ff <= new_rsp;
      end
      if (cmd.emit && hold_valid_ff) begin
         rsp_ff <= {hold_ff[$bits(rsp_type)-1:1], 1'b0};
      end else if (cmd.flush) begin
         rsp_ff <= {hold_ff[$bits(rsp_type)-1:1], 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         tick_count_ff <= '0;
         time_ff <= '0;
         slot_valid_ff <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            period_ff <= csr_wdata;
         end
         if (cmd.tick_mul) begin
            tick_count_ff <= tick_count_ff + 64'd1;
         end
         if (cmd.tick_add) begin
            time_ff <= sat_add(time_ff, {34'd0, inc_ff});
         end
         if (cmd.slot_write) begin
            slot_valid_ff[cmd.idx] <= 1'b1;
         end else if (cmd.slot_clear) begin
            slot_valid_ff[cmd.idx] <= 1'b0;
         end
         if (cmd.emit) begin
            hold_valid_ff <= 1'b1;
         end else if (cmd.flush) begin
            hold_valid_ff <= 1'b0;
         end
         if ((cmd.emit && hold_valid_ff) || cmd.flush) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

@@ rtl/tick_clock_with_sleep_deadlines_core.sv @@
// Top level of the tick clock with sleep deadlines.
// Joins tcsd_ctrl and tcsd_dpath; depends on tcsd_pkg.
//
// Usage: req_data carries one transaction (tick, sleep request or time query),
// taken when req_valid is high and req_stall low. Results leave on rsp_data
// under rsp_valid/rsp_stall; the last result of a transaction has last_result
// set. csr_we with csr_wdata writes the tick period in milliseconds.
// One transaction is worked on at a time; req_stall is high from the cycle after
// acceptance until the block is idle again. A tick scans the 16 sleeper slots
// one per cycle, pausing on a due slot while the result path is full. A sleep
// request whose deadline has not passed scans for a free slot. A monotonic time
// query runs a five-digit reciprocal divider, estimate and remainder per digit.
// The last result appears on rsp_data at the edge where the block returns to idle.
// Results are staged through a one-entry hold register and an output register,
// so a stalled receiver holds the block in place without losing a result.
// Synchronous reset clears the clock, the tick count, all slot valid bits and
// restores a period of 10 ms.
`default_nettype none
module tick_clock_with_sleep_deadlines_core
   import tcsd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   input  req_type   req_data,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output rsp_type   rsp_data,
   input  wire logic csr_we,
   input  wire logic [9:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   tcsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tcsd_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
